/* hw/rtl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helper functions of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

	// Number of double rounds per keystream block (column round + diagonal round).
	localparam int unsigned DOUBLE_ROUNDS = 10;
	localparam int unsigned DR_W          = $clog2(DOUBLE_ROUNDS);
	localparam logic [DR_W-1:0] DR_LAST   = DR_W'(DOUBLE_ROUNDS - 1);

	// Configuration register file.
	localparam int unsigned NUM_CFG   = 6;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_01      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_23      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_45      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_67      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CTR_NONCE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI    = 3'd5;

	typedef logic [31:0] word_t;
	typedef logic [63:0] cfg_word_t;
	typedef logic [2:0]  nbytes_t;

	localparam nbytes_t NB_FULL = 3'd4;

	// The four "expand 32-byte k" constant words.
	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	// Sequencer states of the block-function engine.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	// State index of one quarter-round operand. The row picks a, b, c or d; in a
	// diagonal round the column of row r is shifted left by r.
	function automatic logic [3:0] qr_idx(input logic [1:0] lane, input logic [1:0] row,
			input logic diag);
		logic [1:0] col;
		col = diag ? 2'(lane + row) : lane;
		return {row, col};
	endfunction

	// Rotate left by the amount of the given quarter-round step: 16, 12, 8, 7.
	function automatic word_t qr_rotl(input word_t v, input logic [1:0] step);
		word_t r;
		unique case (step)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[19:0], v[31:20]};
			2'd2: r = {v[23:0], v[31:24]};
			2'd3: r = {v[24:0], v[31:25]};
		endcase
		return r;
	endfunction

	// Mask of the valid low-order bytes of a word.
	function automatic word_t byte_mask(input nbytes_t nb);
		word_t m;
		unique case (nb)
			3'd1:    m = 32'h0000_00ff;
			3'd2:    m = 32'h0000_ffff;
			3'd3:    m = 32'h00ff_ffff;
			3'd4:    m = 32'hffff_ffff;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

endpackage

/* hw/rtl/cc20_if.sv */
// ----------------------------------------------------------------------------
// cc20_if
// Valid/ready channels of the ChaCha20 stream cipher: message words in,
// cipher words out, and the configuration write channel.
// ----------------------------------------------------------------------------

// Message word channel.
interface cc20_in_if import cc20_pkg::*; ();
	logic    valid;
	logic    ready;
	word_t   in_word;
	nbytes_t valid_bytes;
	logic    end_of_message;

	modport source (output valid, output in_word, output valid_bytes,
		output end_of_message, input ready);
	modport sink (input valid, input in_word, input valid_bytes,
		input end_of_message, output ready);
endinterface

// Result word channel.
interface cc20_out_if import cc20_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t out_word;
	logic  out_last;

	modport source (output valid, output out_word, output out_last, input ready);
	modport sink (input valid, input out_word, input out_last, output ready);
endinterface

// Configuration write channel.
interface cc20_cfg_if import cc20_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	cfg_word_t            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/chacha20_stream_cipher.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// Word-serial ChaCha20 encryption/decryption: each message word is XORed with
// the next word of keystream. A word marked last, or one with fewer than four
// valid bytes, ends the message and drops the rest of the current block.
//
// A word that can use the current keystream block goes straight to delivery. A
// word that needs a new block first runs the block function: one shared step
// unit does one add-xor-rotate step of all four quarter rounds per cycle, each
// double round being the column round's steps, then the diagonal round's; then
// the input state is added back and the word delivered. The input is not ready
// while a word is in work; a finished word may wait in the output register
// while the next one is accepted. Configuration is taken at once and must be
// written only while the block is idle; writing the counter register reloads
// the block counter and drops the current block.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import cc20_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	cc20_in_if.sink      data_in,
	cc20_out_if.source   data_out,
	cc20_cfg_if.sink     cfg
);

	state_t          state_q;
	cfg_word_t       cfg_q [NUM_CFG];
	word_t           st_q [16];
	word_t           init_w [16];
	logic [3:0]      pos_q;
	logic            blk_rdy_q;
	word_t           ctr_q;
	logic [1:0]      step_q;
	logic            diag_q;
	logic [DR_W-1:0] dr_q;

	word_t   word_q;
	nbytes_t nb_q;
	logic    last_q;

	word_t out_word_q;
	logic  out_last_q;
	logic  ov_q;

	logic    in_acc;
	logic    cfg_acc;
	logic    emit_go;
	nbytes_t nb_in;
	logic    last_in;
	logic    need_blk;

	word_t sum_w [4];
	word_t rot_w [4];

	// Handshakes.
	assign data_in.ready = (state_q == ST_IDLE);
	assign in_acc        = data_in.valid && data_in.ready;
	assign cfg.ready     = 1'b1;
	assign cfg_acc       = cfg.valid && cfg.ready;
	assign emit_go       = (state_q == ST_EMIT) && (!ov_q || data_out.ready);

	// Decode the incoming word: clamp the byte count and find the message end.
	assign nb_in    = (data_in.valid_bytes > NB_FULL) ? NB_FULL : data_in.valid_bytes;
	assign last_in  = data_in.end_of_message || (nb_in < NB_FULL);
	assign need_blk = (nb_in != 3'd0) && !blk_rdy_q;

	// Initial block state from the constants, key, counter and nonce.
	always_comb begin
		init_w[0] = SIGMA_0;
		init_w[1] = SIGMA_1;
		init_w[2] = SIGMA_2;
		init_w[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = cfg_q[i][31:0];
			init_w[5 + 2 * i] = cfg_q[i][63:32];
		end
		init_w[12] = ctr_q;
		init_w[13] = cfg_q[CFG_CTR_NONCE_LO][63:32];
		init_w[14] = cfg_q[CFG_NONCE_HI][31:0];
		init_w[15] = cfg_q[CFG_NONCE_HI][63:32];
	end

	// Shared step unit: one add-xor-rotate step of the four quarter rounds.
	// Even steps add b into a and mix d; odd steps add d into c and mix b.
	always_comb begin
		word_t a_v, b_v, c_v, d_v, p_v, q_v, r_v;
		for (int l = 0; l < 4; l++) begin
			a_v = st_q[qr_idx(2'(l), 2'd0, 1'b0)];
			b_v = diag_q ? st_q[qr_idx(2'(l), 2'd1, 1'b1)] : st_q[qr_idx(2'(l), 2'd1, 1'b0)];
			c_v = diag_q ? st_q[qr_idx(2'(l), 2'd2, 1'b1)] : st_q[qr_idx(2'(l), 2'd2, 1'b0)];
			d_v = diag_q ? st_q[qr_idx(2'(l), 2'd3, 1'b1)] : st_q[qr_idx(2'(l), 2'd3, 1'b0)];
			p_v = step_q[0] ? c_v : a_v;
			q_v = step_q[0] ? d_v : b_v;
			r_v = step_q[0] ? b_v : d_v;
			sum_w[l] = p_v + q_v;
			rot_w[l] = qr_rotl(r_v ^ sum_w[l], step_q);
		end
	end

	// Working state and keystream block.
	always_ff @(posedge clk) begin
		if (in_acc && need_blk) begin
			for (int i = 0; i < 16; i++) begin
				st_q[i] <= init_w[i];
			end
		end else if (state_q == ST_ROUND) begin
			for (int l = 0; l < 4; l++) begin
				if (!step_q[0]) begin
					st_q[qr_idx(2'(l), 2'd0, 1'b0)] <= sum_w[l];
					if (diag_q) begin
						st_q[qr_idx(2'(l), 2'd3, 1'b1)] <= rot_w[l];
					end else begin
						st_q[qr_idx(2'(l), 2'd3, 1'b0)] <= rot_w[l];
					end
				end else begin
					if (diag_q) begin
						st_q[qr_idx(2'(l), 2'd2, 1'b1)] <= sum_w[l];
						st_q[qr_idx(2'(l), 2'd1, 1'b1)] <= rot_w[l];
					end else begin
						st_q[qr_idx(2'(l), 2'd2, 1'b0)] <= sum_w[l];
						st_q[qr_idx(2'(l), 2'd1, 1'b0)] <= rot_w[l];
					end
				end
			end
		end else if (state_q == ST_FINAL) begin
			for (int i = 0; i < 16; i++) begin
				st_q[i] <= st_q[i] + init_w[i];
			end
		end
	end

	// Captured message word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_q <= data_in.in_word;
			nb_q   <= nb_in;
			last_q <= last_in;
		end
	end

	// Sequencer and round counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 2'd0;
			diag_q  <= 1'b0;
			dr_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q  <= 2'd0;
						diag_q  <= 1'b0;
						dr_q    <= '0;
						state_q <= need_blk ? ST_ROUND : ST_EMIT;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						diag_q <= !diag_q;
						if (diag_q) begin
							if (dr_q == DR_LAST) begin
								dr_q    <= '0;
								state_q <= ST_FINAL;
							end else begin
								dr_q <= dr_q + DR_W'(1);
							end
						end
					end
				end
				ST_FINAL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers, block counter and keystream position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= '0;
			end
			ctr_q     <= '0;
			blk_rdy_q <= 1'b0;
			pos_q     <= '0;
		end else begin
			// A fresh block is ready and the counter moves on.
			if (state_q == ST_FINAL) begin
				ctr_q     <= ctr_q + 32'd1;
				blk_rdy_q <= 1'b1;
				pos_q     <= '0;
			end
			// Consume one keystream word; the message end drops the block.
			if (emit_go) begin
				if (nb_q != 3'd0) begin
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd15) begin
						blk_rdy_q <= 1'b0;
					end
				end
				if (last_q) begin
					blk_rdy_q <= 1'b0;
					pos_q     <= '0;
				end
			end
			// Register writes; out-of-range indexes are ignored.
			if (cfg_acc && (cfg.index < CFG_IDX_W'(NUM_CFG))) begin
				cfg_q[cfg.index] <= cfg.data;
				if (cfg.index == CFG_CTR_NONCE_LO) begin
					ctr_q     <= cfg.data[31:0];
					blk_rdy_q <= 1'b0;
					pos_q     <= '0;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_go) begin
			ov_q <= 1'b1;
		end else if (data_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_word_q <= (word_q ^ st_q[pos_q]) & byte_mask(nb_q);
			out_last_q <= last_q;
		end
	end

	assign data_out.valid    = ov_q;
	assign data_out.out_word = out_word_q;
	assign data_out.out_last = out_last_q;

endmodule

/* hw/rtl/cc20_checker.sv */
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks of the ChaCha20 stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module cc20_checker import cc20_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t out_word,
	input logic  out_last
);

	logic [1:0] pend_q;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= 2'(pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready));
		end
	end

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("result word changed while stalled");

	// The block takes one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted word");

	// Every result word belongs to an accepted input word.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result word without an input word");

	// At most one word in work and one waiting in the output register.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many words outstanding");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data_in.valid),
	.in_ready  (data_in.ready),
	.out_valid (data_out.valid),
	.out_ready (data_out.ready),
	.out_word  (data_out.out_word),
	.out_last  (data_out.out_last)
);
